// ----- hdl/mhms_pkg.sv -----
// ----------------------------------------------------------------------------
// mhms_pkg
// shared constants and types for the min-heap merge sorter: item structs,
// the per-cell command and link, and the control state enum
// ----------------------------------------------------------------------------
package mhms_pkg;

   localparam int STORE_DEPTH = 64;
   localparam int DATA_WIDTH  = 32;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] element_value;
      logic                         value_present;
      logic                         end_of_set;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sorted_value;
      logic                         last_of_run;
      logic                         overflow_seen;
   } rsp_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic                         insert;
      logic                         pop;
      logic signed [DATA_WIDTH-1:0] value;
   } cell_cmd_type;

   // what one cell shows its neighbors
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         valid;
      logic                         greater;
   } cell_link_type;

   typedef enum logic {
      ST_COLLECT,
      ST_DRAIN
   } state_type;

endpackage

// ----- hdl/mhms_cell.sv -----
// ----------------------------------------------------------------------------
// mhms_cell
// one slot of the sorting chain: holds one element, shifts up on insert
// when larger than the new element, shifts down on pop
// ----------------------------------------------------------------------------
module mhms_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  mhms_pkg::cell_cmd_type cmd,
   input  mhms_pkg::cell_link_type left_link,
   input  mhms_pkg::cell_link_type right_link,
   output mhms_pkg::cell_link_type link
);
   import mhms_pkg::*;

   logic signed [DATA_WIDTH-1:0] value_ff;
   logic signed [DATA_WIDTH-1:0] value_in;
   logic                         valid_ff;
   logic                         valid_in;
   logic                         greater;

   // equal values stay put, so duplicates keep arrival order
   assign greater = valid_ff && (value_ff > cmd.value);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (cmd.pop) begin
         value_in = right_link.value;
         valid_in = right_link.valid;
      end else if (cmd.insert) begin
         if (!valid_ff || greater) begin
            if (left_link.greater) begin
               value_in = left_link.value;
            end else begin
               value_in = cmd.value;
            end
         end
         valid_in = valid_ff | left_link.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign link.value   = value_ff;
   assign link.valid   = valid_ff;
   assign link.greater = greater;

endmodule

// ----- hdl/mhms_chain.sv -----
// ----------------------------------------------------------------------------
// mhms_chain
// row of sorting cells, kept in ascending order from cell 0 upward
// ----------------------------------------------------------------------------
module mhms_chain (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mhms_pkg::cell_cmd_type                 cmd,
   output mhms_pkg::cell_link_type                head,
   output logic [mhms_pkg::STORE_DEPTH-1:0]       valid
);
   import mhms_pkg::*;

   cell_link_type links [STORE_DEPTH];
   cell_link_type left_edge;
   cell_link_type right_edge;

   // below cell 0 sits an always-valid, never-greater slot; above the top, nothing
   assign left_edge  = '{value: '0, valid: 1'b1, greater: 1'b0};
   assign right_edge = '{value: '0, valid: 1'b0, greater: 1'b0};

   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      cell_link_type left_link;
      cell_link_type right_link;

      if (i == 0) begin : g_first
         assign left_link = left_edge;
      end else begin : g_mid_left
         assign left_link = links[i-1];
      end

      if (i == STORE_DEPTH - 1) begin : g_last
         assign right_link = right_edge;
      end else begin : g_mid_right
         assign right_link = links[i+1];
      end

      mhms_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_link  (left_link),
         .right_link (right_link),
         .link       (links[i])
      );

      assign valid[i] = links[i].valid;
   end

   assign head = links[0];

endmodule

// ----- hdl/min_heap_merge_sorter.sv -----
// ----------------------------------------------------------------------------
// min_heap_merge_sorter
// sorts a set of signed elements in an insertion chain and emits them in
// ascending order when the end-of-set item arrives
// ----------------------------------------------------------------------------
// throughput: one item per cycle while collecting; after an end item no item is
//    taken until the stored elements have drained out, which output stalls can hold up
// drain: the end item sets the drain state; each pop moves the head into the output
//    register, one per cycle unless stalled, as the chain shifts down one slot per pop
// reset: synchronous, clears the cell valid bits, overflow flag, state and
//    output valid; stored values are left as they are
module min_heap_merge_sorter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mhms_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mhms_pkg::rsp_type rsp_item
);
   import mhms_pkg::*;

   state_type              state_ff;
   state_type              state_in;
   logic                   overflow_ff;
   logic                   overflow_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   cell_cmd_type           cmd;
   cell_link_type          head;
   logic [STORE_DEPTH-1:0] chain_valid;

   logic                   accept;
   logic                   full;
   logic                   out_free;
   logic                   pop;
   logic                   pop_last;

   // the chain is full once its top cell holds an element
   assign full     = chain_valid[STORE_DEPTH-1];
   assign accept   = req_valid && !req_stall;
   // output register can take a new result this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == ST_DRAIN) && out_free && head.valid;
   // the result being popped is the last one when the next cell is empty
   assign pop_last = pop && !chain_valid[1];

   assign req_stall = (state_ff == ST_DRAIN);

   mhms_chain u_chain (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .head  (head),
      .valid (chain_valid)
   );

   always_comb begin
      state_in     = state_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      cmd.insert   = 1'b0;
      cmd.pop      = 1'b0;
      cmd.value    = req_item.element_value;

      // output register drains when the receiver takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_COLLECT: begin
            if (accept) begin
               if (req_item.value_present) begin
                  if (full) begin
                     // element dropped, whole set gets flagged
                     overflow_in = 1'b1;
                  end else begin
                     cmd.insert = 1'b1;
                  end
               end
               if (req_item.end_of_set) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (pop) begin
               cmd.pop                = 1'b1;
               rsp_valid_in           = 1'b1;
               rsp_in.sorted_value    = head.value;
               rsp_in.last_of_run     = !chain_valid[1];
               rsp_in.overflow_seen   = overflow_ff;
            end
            // empty set, or last element going out now
            if (!head.valid || pop_last) begin
               state_in    = ST_COLLECT;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // occupied cells always form a contiguous run starting at cell 0
   assert property (@(posedge clock) disable iff (reset)
      (chain_valid & (chain_valid + STORE_DEPTH'(1))) == '0)
      else $error("chain occupancy is not contiguous");

   // popping the last element leaves the chain empty
   assert property (@(posedge clock) disable iff (reset)
      pop_last |=> !chain_valid[0])
      else $error("chain not empty after last pop");

   // an overflow while collecting can only come from a full chain
   assert property (@(posedge clock) disable iff (reset)
      (overflow_ff && state_ff == ST_COLLECT) |-> full)
      else $error("overflow flagged with free cells");

   // a result flagged last ends the drain
   assert property (@(posedge clock) disable iff (reset)
      pop_last |=> state_ff == ST_COLLECT && !overflow_ff)
      else $error("drain did not finish after last result");

endmodule

// ----- tb/sv/min_heap_merge_sorter_checker.sv -----
// ----------------------------------------------------------------------------
// min_heap_merge_sorter_checker
// watches both channels of the sorter, keeps its own ascending copy of the
// collected set and the drop flag, and compares every emitted item field by
// field against the oldest sorted value still owed
// ----------------------------------------------------------------------------
module min_heap_merge_sorter_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  mhms_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  mhms_pkg::rsp_type rsp_item,
   output int                error_count,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import mhms_pkg::*;

   logic signed [DATA_WIDTH-1:0] held_sorted[$];
   logic                         dropped;
   rsp_type                      sorted_due[$];

   initial begin
      error_count   = 0;
      pending_count = 0;
      dropped       = 1'b0;
   end

   task automatic report_mismatch(input string what, input rsp_type got, input rsp_type want);
      $display("mismatch on %s: got %0d/%0b/%0b, want %0d/%0b/%0b", what,
               got.sorted_value, got.last_of_run, got.overflow_seen,
               want.sorted_value, want.last_of_run, want.overflow_seen);
      error_count++;
   endtask

   // insert behind equal values, emit the whole set on an end item
   task automatic take_request(input req_type it);
      int      pos;
      rsp_type due;
      if (it.value_present) begin
         if (held_sorted.size() >= STORE_DEPTH) begin
            dropped = 1'b1;
         end else begin
            pos = held_sorted.size();
            while (pos > 0 && held_sorted[pos-1] > it.element_value) pos--;
            held_sorted.insert(pos, it.element_value);
         end
      end
      if (it.end_of_set) begin
         foreach (held_sorted[i]) begin
            due.sorted_value  = held_sorted[i];
            due.last_of_run   = (i == held_sorted.size() - 1);
            due.overflow_seen = dropped;
            sorted_due.insert(sorted_due.size(), due);
         end
         held_sorted.delete();
         dropped = 1'b0;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         held_sorted.delete();
         sorted_due.delete();
         dropped = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sorted_due.size() == 0) begin
               report_mismatch("unexpected item", rsp_item, '0);
            end else begin
               want = sorted_due.pop_front();
               if (rsp_item.sorted_value !== want.sorted_value)
                  report_mismatch("sorted_value", rsp_item, want);
               if (rsp_item.last_of_run !== want.last_of_run)
                  report_mismatch("last_of_run", rsp_item, want);
               if (rsp_item.overflow_seen !== want.overflow_seen)
                  report_mismatch("overflow_seen", rsp_item, want);
            end
         end
         if (req_valid && !req_stall) take_request(req_item);
      end
      pending_count = sorted_due.size();
   end

endmodule

// ----- tb/sv/min_heap_merge_sorter_test.sv -----
// ----------------------------------------------------------------------------
// min_heap_merge_sorter_test
// drives sets of signed elements into the sorter, with empty end markers,
// ignored items, full and overflowing stores, under random sender and
// receiver idling; a checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module min_heap_merge_sorter_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mhms_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 200;

   // extremes of the element field
   localparam logic signed [DATA_WIDTH-1:0] TOP_VALUE    = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] BOTTOM_VALUE = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_item;

   int error_count;
   int pending_count;
   int sender_idle_pct;
   int receiver_idle_pct;
   int cycle_count = 0;
   int items_sent;
   int set_index;
   int set_len;

   min_heap_merge_sorter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   min_heap_merge_sorter_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_item      (rsp_item),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // 2 ns clock, first rising edge at 1 ns
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // run guard: a hung handshake or a missing item ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver back-pressure, one decision per cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
   end

   function automatic req_type make_req(input logic signed [DATA_WIDTH-1:0] value,
                                        input logic present, input logic closes_set);
      req_type r;
      r.element_value = value;
      r.value_present = present;
      r.end_of_set    = closes_set;
      return r;
   endfunction

   // mix of extremes, a narrow band around zero for duplicates, and full range
   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      int near;
      near = $urandom_range(0, 16);
      case ($urandom_range(0, 9))
         0:       return TOP_VALUE;
         1:       return BOTTOM_VALUE;
         2, 3:    return near - 8;
         default: return $urandom;
      endcase
   endfunction

   // optional idle cycles, then hold the item until the block takes it;
   // valid is lowered only in steps where it is not raised again
   task automatic send_item(input req_type it);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // one set of len elements; the last one rides on the end item when asked,
   // and ignored items are sprinkled in between
   task automatic run_set(input int len, input bit end_has_value);
      int i;
      for (i = 0; i < len - (end_has_value ? 1 : 0); i++) begin
         if ($urandom_range(0, 9) == 0) send_item(make_req($urandom, 1'b0, 1'b0));
         send_item(make_req(pick_value(), 1'b1, 1'b0));
         items_sent++;
      end
      send_item(make_req(end_has_value ? pick_value() : $urandom, end_has_value, 1'b1));
      items_sent++;
   endtask

   initial begin
      // phase one: sender rarely idles, receiver mostly stalls
      sender_idle_pct   = 18;
      receiver_idle_pct = 85;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_item  <= '0;
      rsp_stall <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // --- directed items ---
      // end marker on an empty store: no items out
      send_item(make_req($urandom, 1'b0, 1'b0 | 1'b1));
      // neither element nor end: nothing happens
      send_item(make_req($urandom, 1'b0, 1'b0));
      // extremes, zero, neighbors of zero and duplicates, closed by an
      // end item that also carries an element equal to one already held
      send_item(make_req(TOP_VALUE, 1'b1, 1'b0));
      send_item(make_req(BOTTOM_VALUE, 1'b1, 1'b0));
      send_item(make_req('0, 1'b1, 1'b0));
      send_item(make_req(-1, 1'b1, 1'b0));
      send_item(make_req(1, 1'b1, 1'b0));
      send_item(make_req(5, 1'b1, 1'b0));
      send_item(make_req($urandom, 1'b0, 1'b0));
      send_item(make_req(5, 1'b1, 1'b0));
      send_item(make_req(-1, 1'b1, 1'b0));
      send_item(make_req(TOP_VALUE, 1'b1, 1'b1));
      // one-element set carried entirely by the end item
      send_item(make_req(-7, 1'b1, 1'b1));
      // empty set again right after a drain
      send_item(make_req('0, 1'b0, 1'b1));

      // --- random sets ---
      items_sent = 0;
      set_index  = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= 2 * RANDOM_ITEMS / 3) begin
            // phase three: no idling on either side
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end else if (items_sent >= RANDOM_ITEMS / 3) begin
            // phase two: sender mostly idle, receiver rarely stalls
            sender_idle_pct   = 85;
            receiver_idle_pct = 18;
         end
         if (set_index == 0)
            set_len = STORE_DEPTH + $urandom_range(1, 6);        // drops a few
         else if (set_index == 3)
            set_len = STORE_DEPTH;                               // exactly full
         else if ($urandom_range(0, 9) == 0)
            set_len = 0;                                         // bare end marker
         else if ($urandom_range(0, 14) == 0)
            set_len = $urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 3);
         else
            set_len = $urandom_range(1, 12);
         run_set(set_len, (set_len > 0) && ($urandom_range(0, 1) == 1));
         set_index++;
      end
      req_valid <= 1'b0;

      // drain: wait until every owed item came back, then watch for strays
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
